// ===== src/tibce_pkg.sv =====
// ----------------------------------------------------------------------------
// tibce_pkg: shared types and constants of the IT block condition expander
// Condition codes, error codes and the item and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package tibce_pkg;

  localparam int unsigned COND_W     = 4;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned ELSE_W     = 3;
  localparam int unsigned MAX_BLOCK  = 4;

  localparam logic [COND_W-1:0] COND_AL = 4'd14;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_ELSE_AL     = 2'd1,
    ERR_COND_IN_BLK = 2'd2,
    ERR_END_IN_BLK  = 2'd3
  } tibce_err_e;

  typedef struct packed {
    logic              is_it;
    logic [COND_W-1:0] first_cond;
    logic [LEN_W-1:0]  block_len;
    logic [ELSE_W-1:0] else_pattern;
    logic [COND_W-1:0] ins_cond;
    logic              end_of_stream;
  } tibce_item_t;

  typedef struct packed {
    logic [COND_W-1:0] assigned_cond;
    logic              conditional;
    logic              made_noop;
    logic              in_block;
    tibce_err_e        error;
  } tibce_res_t;

endpackage

`default_nettype wire

// ===== src/tibce_ifs.sv =====
// ----------------------------------------------------------------------------
// tibce_ifs: channel interfaces of the IT block condition expander
// Valid/ready channels for decoded instructions and for expanded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tibce_in_if;
  logic       valid;
  logic       ready;
  logic       is_it;
  logic [3:0] first_cond;
  logic [2:0] block_len;
  logic [2:0] else_pattern;
  logic [3:0] ins_cond;
  logic       end_of_stream;

  modport source (
    output valid, is_it, first_cond, block_len, else_pattern, ins_cond, end_of_stream,
    input  ready
  );
  modport sink (
    input  valid, is_it, first_cond, block_len, else_pattern, ins_cond, end_of_stream,
    output ready
  );
endinterface

interface tibce_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] assigned_cond;
  logic       conditional;
  logic       made_noop;
  logic       in_block;
  logic [1:0] error;

  modport source (
    output valid, assigned_cond, conditional, made_noop, in_block, error,
    input  ready
  );
  modport sink (
    input  valid, assigned_cond, conditional, made_noop, in_block, error,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/tibce_core.sv =====
// ----------------------------------------------------------------------------
// tibce_core: IT state register and per-instruction condition logic
// Holds the open block and works out one result for each instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module tibce_core
  import tibce_pkg::*;
#(
  parameter int unsigned MaxBlock = MAX_BLOCK
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire tibce_item_t item_i,
  input  wire              fire_i,
  output tibce_res_t       res_o
);

  logic [COND_W-1:0] cond_q, cond_d;
  logic [ELSE_W-1:0] else_q, else_d;
  logic [LEN_W-1:0]  slots_q, slots_d;

  logic [LEN_W-1:0]  sm1;
  logic              else_bit;
  logic [COND_W-1:0] slot_cond;
  logic [LEN_W-1:0]  len;
  logic [3:0]        mask4;
  logic [ELSE_W-1:0] eff_else;
  logic [ELSE_W-1:0] stored;

  always_comb begin
    sm1       = slots_q - 3'd1;
    else_bit  = (sm1 < 3'd3) ? else_q[sm1[1:0]] : 1'b0;
    slot_cond = cond_q ^ {3'b000, else_bit};

    if (item_i.block_len == 3'd0) begin
      len = 3'd1;
    end else if (item_i.block_len > LEN_W'(MaxBlock)) begin
      len = LEN_W'(MaxBlock);
    end else begin
      len = item_i.block_len;
    end
    mask4    = (4'd1 << (len - 3'd1)) - 4'd1;
    eff_else = item_i.else_pattern & mask4[2:0];

    // The first pattern bit belongs to the second slot, which is taken with
    // the highest remaining index, so the pattern is stored reversed.
    case (len)
      3'd2:    stored = {2'b00, eff_else[0]};
      3'd3:    stored = {1'b0, eff_else[0], eff_else[1]};
      3'd4:    stored = {eff_else[0], eff_else[1], eff_else[2]};
      default: stored = '0;
    endcase
  end

  always_comb begin
    cond_d  = cond_q;
    else_d  = else_q;
    slots_d = slots_q;

    res_o.assigned_cond = item_i.ins_cond;
    res_o.conditional   = 1'b0;
    res_o.made_noop     = 1'b0;
    res_o.in_block      = 1'b0;
    res_o.error         = ERR_NONE;

    if (slots_q != 3'd0) begin
      res_o.in_block = 1'b1;
      if (item_i.ins_cond != COND_AL) begin
        res_o.error = ERR_COND_IN_BLK;
        cond_d  = '0;
        else_d  = '0;
        slots_d = '0;
      end else begin
        res_o.assigned_cond = slot_cond;
        res_o.conditional   = (slot_cond != COND_AL);
        if ((item_i.end_of_stream && (sm1 != 3'd0)) || (sm1 == 3'd0)) begin
          if (sm1 != 3'd0) begin
            res_o.error = ERR_END_IN_BLK;
          end
          cond_d  = '0;
          else_d  = '0;
          slots_d = '0;
        end else begin
          slots_d = sm1;
        end
      end
    end else if (item_i.is_it) begin
      res_o.made_noop = 1'b1;
      if ((item_i.first_cond == COND_AL) && (eff_else != 3'd0)) begin
        res_o.error = ERR_ELSE_AL;
      end else if (item_i.end_of_stream) begin
        res_o.error = ERR_END_IN_BLK;
      end else begin
        cond_d  = item_i.first_cond;
        else_d  = stored;
        slots_d = len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_q  <= '0;
      else_q  <= '0;
      slots_q <= '0;
    end else if (fire_i) begin
      cond_q  <= cond_d;
      else_q  <= else_d;
      slots_q <= slots_d;
    end
  end

`ifndef SYNTHESIS
  a_slots_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_q <= LEN_W'(MaxBlock))
    else $error("slot count exceeds the largest block");

  a_closed_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slots_q == 3'd0) |-> ((cond_q == '0) && (else_q == '0)))
    else $error("closed block left stale condition state");

  a_error_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (res_o.error != ERR_NONE)) |=> (slots_q == 3'd0))
    else $error("block still open after an error");

  a_noop_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.made_noop) |-> (!res_o.in_block && (slots_q == 3'd0)))
    else $error("IT made a no-op inside a block");
`endif

endmodule

`default_nettype wire

// ===== src/thumb_it_block_condition_expander_unit.sv =====
// ----------------------------------------------------------------------------
// thumb_it_block_condition_expander_unit: Thumb-2 IT block condition expander
// A result passes from the input register, where its instruction beat is
// taken, to the result register, from which it is presented.
// Throughput: one instruction per cycle while the result side keeps up.
// Reset clears the open block and both pipeline valid flags at once.
// ----------------------------------------------------------------------------
`default_nettype none

module thumb_it_block_condition_expander_unit
  import tibce_pkg::*;
#(
  parameter int unsigned MaxBlock = MAX_BLOCK
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tibce_in_if.sink    in_i,
  tibce_out_if.source out_o
);

  // The design is a two-register pipeline. An input register captures each
  // instruction beat; once the result register has room, the core works
  // out its result from the IT state and writes both the state and the
  // result register. Each stage moves on whenever the stage after it is free
  // or is emptying in the same cycle, so a full pipeline keeps taking one beat
  // a cycle while the consumer keeps up, and stalls cleanly when it does not.

  tibce_item_t item_q;
  logic        item_valid_q;
  tibce_res_t  res_d, res_q;
  logic        res_valid_q;

  logic res_free;
  logic fire;

  // The result register can take a new value when empty or being drained.
  assign res_free = !res_valid_q || out_o.ready;
  // An instruction is processed when it sits in the input register and the
  // result register has room; only then does the IT state advance.
  assign fire     = item_valid_q && res_free;
  assign in_i.ready = !item_valid_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        item_valid_q <= in_i.valid;
      end
      if (res_free) begin
        res_valid_q <= item_valid_q;
      end
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.is_it         <= in_i.is_it;
      item_q.first_cond    <= in_i.first_cond;
      item_q.block_len     <= in_i.block_len;
      item_q.else_pattern  <= in_i.else_pattern;
      item_q.ins_cond      <= in_i.ins_cond;
      item_q.end_of_stream <= in_i.end_of_stream;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  tibce_core #(
    .MaxBlock (MaxBlock)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_q),
    .fire_i (fire),
    .res_o  (res_d)
  );

  assign out_o.valid         = res_valid_q;
  assign out_o.assigned_cond = res_q.assigned_cond;
  assign out_o.conditional   = res_q.conditional;
  assign out_o.made_noop     = res_q.made_noop;
  assign out_o.in_block      = res_q.in_block;
  assign out_o.error         = res_q.error;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Thumb-2 IT block condition expander
// Drives decoded instructions with random gaps, stalls the result side at
// random, and compares every result beat with an in-bench IT state predictor.
// ----------------------------------------------------------------------------

module tb_top;

  import tibce_pkg::*;

  // Cycles without any beat on either channel before the run is given up.
  // The slowest legal stretch is a sender gap plus pipeline latency plus a
  // receiver stall, so this leaves ample margin.
  localparam int unsigned IdleLimit    = 1000;
  localparam int unsigned RandomInstrs = 1500;
  localparam int unsigned MaxGap       = 11;
  localparam int unsigned PrintCap     = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: carries its own copy of the IT state, works out the result of
  // every accepted instruction and holds those results until the block
  // delivers them.
  // --------------------------------------------------------------------------
  class cond_expansion_board;
    logic [COND_W-1:0] blk_cond;
    logic [ELSE_W-1:0] else_left;
    logic [LEN_W-1:0]  slots_left;
    tibce_res_t        expected_results[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       blocks_opened;
    int unsigned       flags_seen[4];

    function new();
      close_block();
      mismatches    = 0;
      checked       = 0;
      blocks_opened = 0;
      foreach (flags_seen[i]) flags_seen[i] = 0;
    endfunction

    function void close_block();
      blk_cond   = '0;
      else_left  = '0;
      slots_left = '0;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // Works out the result of one accepted instruction and advances the state.
    function void expand_instr(tibce_item_t it);
      tibce_res_t        r;
      int unsigned       len;
      int unsigned       s;
      logic [ELSE_W-1:0] used_else;
      logic [ELSE_W-1:0] stored;
      logic              inverse;
      logic [COND_W-1:0] c;

      r.assigned_cond = it.ins_cond;
      r.conditional   = 1'b0;
      r.made_noop     = 1'b0;
      r.in_block      = 1'b0;
      r.error         = ERR_NONE;

      if (slots_left != 0) begin
        // Every instruction here is a block slot, an IT included.
        r.in_block = 1'b1;
        if (it.ins_cond != COND_AL) begin
          r.error = ERR_COND_IN_BLK;
          close_block();
        end else begin
          s       = slots_left;
          inverse = (s <= 3) ? else_left[s-1] : 1'b0;
          c       = blk_cond ^ {{(COND_W-1){1'b0}}, inverse};
          r.assigned_cond = c;
          r.conditional   = (c != COND_AL);
          s = s - 1;
          if (it.end_of_stream && s != 0) begin
            r.error = ERR_END_IN_BLK;
            s = 0;
          end
          if (s == 0) begin
            close_block();
          end else begin
            slots_left = LEN_W'(s);
          end
        end
      end else if (it.is_it) begin
        r.made_noop = 1'b1;
        len = it.block_len;
        if (len < 1) len = 1;
        if (len > MAX_BLOCK) len = MAX_BLOCK;
        used_else = it.else_pattern & ELSE_W'((1 << (len - 1)) - 1);
        if (it.first_cond == COND_AL && used_else != 0) begin
          r.error = ERR_ELSE_AL;
        end else if (it.end_of_stream) begin
          r.error = ERR_END_IN_BLK;
        end else begin
          // Reverse the pattern so that the slot with s left reads bit s-1.
          stored = '0;
          for (int j = 0; j + 1 < int'(len); j++) begin
            if (used_else[int'(len) - 2 - j]) stored[j] = 1'b1;
          end
          blk_cond   = it.first_cond;
          else_left  = stored;
          slots_left = LEN_W'(len);
          blocks_opened++;
        end
      end

      flags_seen[int'(r.error)]++;
      expected_results.push_back(r);
    endfunction

    // Prints one line per mismatch, up to a cap, and counts them all.
    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PrintCap) $display("%0t MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(tibce_res_t got);
      tibce_res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with none outstanding (cond %0d, error %0d)",
                                  got.assigned_cond, got.error));
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.assigned_cond !== want.assigned_cond)
        report_mismatch($sformatf("result %0d: assigned_cond %0d, expected %0d",
                                  checked, got.assigned_cond, want.assigned_cond));
      if (got.conditional !== want.conditional)
        report_mismatch($sformatf("result %0d: conditional %0b, expected %0b",
                                  checked, got.conditional, want.conditional));
      if (got.made_noop !== want.made_noop)
        report_mismatch($sformatf("result %0d: made_noop %0b, expected %0b",
                                  checked, got.made_noop, want.made_noop));
      if (got.in_block !== want.in_block)
        report_mismatch($sformatf("result %0d: in_block %0b, expected %0b",
                                  checked, got.in_block, want.in_block));
      if (got.error !== want.error)
        report_mismatch($sformatf("result %0d: error %0d, expected %s",
                                  checked, got.error, want.error.name()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  tibce_in_if  in_if ();
  tibce_out_if out_if ();

  thumb_it_block_condition_expander_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cond_expansion_board board = new();

  int unsigned beats_sent;
  int unsigned idle_cycles;
  bit          sender_quiet;
  bit          sink_quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A quiet side runs back to back; otherwise each beat waits a random gap.
  function automatic int unsigned draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic tibce_item_t make_instr(logic is_it, logic [COND_W-1:0] fc,
                                             logic [LEN_W-1:0] len,
                                             logic [ELSE_W-1:0] pattern,
                                             logic [COND_W-1:0] ic, logic eos);
    tibce_item_t it;
    it.is_it         = is_it;
    it.first_cond    = fc;
    it.block_len     = len;
    it.else_pattern  = pattern;
    it.ins_cond      = ic;
    it.end_of_stream = eos;
    return it;
  endfunction

  // Every field random over its full width; the end-of-stream flag is kept
  // rare so that blocks get a fair chance to run to their last slot.
  function automatic tibce_item_t random_instr();
    return make_instr(1'($urandom_range(0, 1)), COND_W'($urandom_range(0, 15)),
                      LEN_W'($urandom_range(0, 7)), ELSE_W'($urandom_range(0, 7)),
                      COND_W'($urandom_range(0, 15)), $urandom_range(0, 9) == 0);
  endfunction

  // Called at a falling edge, returns at a falling edge. Valid is only lowered
  // when a gap is actually taken, so it never sees two updates in one step.
  task automatic send_instr(tibce_item_t it);
    int unsigned gap;
    gap = draw_gap(sender_quiet);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.is_it         <= it.is_it;
    in_if.first_cond    <= it.first_cond;
    in_if.block_len     <= it.block_len;
    in_if.else_pattern  <= it.else_pattern;
    in_if.ins_cond      <= it.ins_cond;
    in_if.end_of_stream <= it.end_of_stream;
    in_if.valid         <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    board.expand_instr(it);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // An IT header followed by one instruction per slot. Most slots are plain
  // AL instructions so that blocks usually complete; a few carry their own
  // condition, an IT of their own or an early end of stream.
  task automatic send_it_block();
    tibce_item_t it;
    tibce_item_t slot;
    int unsigned len;
    it = random_instr();
    it.is_it = 1'b1;
    it.end_of_stream = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 9) != 0) it.block_len = LEN_W'($urandom_range(1, MAX_BLOCK));
    if (it.first_cond == COND_AL && $urandom_range(0, 3) != 0) it.else_pattern = '0;
    send_instr(it);
    len = (it.block_len == 0) ? 1 : (it.block_len > MAX_BLOCK ? MAX_BLOCK : it.block_len);
    for (int k = 0; k < int'(len); k++) begin
      slot = random_instr();
      if ($urandom_range(0, 9) != 0) slot.ins_cond = COND_AL;
      slot.is_it         = ($urandom_range(0, 4) == 0);
      slot.end_of_stream = ($urandom_range(0, 29) == 0);
      send_instr(slot);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, with quiet stretches now and then.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    sink_quiet   = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_gap(sink_quiet);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
      if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and watchdog. Both channels are sampled at the rising edge, so the
  // values seen are those from before the block's own updates.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tibce_res_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.assigned_cond = out_if.assigned_cond;
        got.conditional   = out_if.conditional;
        got.made_noop     = out_if.made_noop;
        got.in_block      = out_if.in_block;
        got.error         = tibce_err_e'(out_if.error);
        board.check_result(got);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                   IdleLimit, board.outstanding());
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    bit paused;
    in_if.valid         = 1'b0;
    in_if.is_it         = 1'b0;
    in_if.first_cond    = '0;
    in_if.block_len     = '0;
    in_if.else_pattern  = '0;
    in_if.ins_cond      = '0;
    in_if.end_of_stream = 1'b0;
    beats_sent   = 0;
    idle_cycles  = 0;
    sender_quiet = 1'b0;
    paused       = 1'b0;
    rst_ni       = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. Ordinary instructions outside a block pass through, an
    // end of stream there being harmless.
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, 4'd0, 1'b0));
    send_instr(make_instr(1'b0, 4'd15, 3'd7, 3'd7, 4'd15, 1'b1));
    // Full four-slot block on EQ, pattern then/else/then/else.
    send_instr(make_instr(1'b1, 4'd0, 3'd4, 3'b101, COND_AL, 1'b0));
    repeat (4) send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b0));
    // First condition NV: its inverse is AL, so the else slot is unconditional.
    send_instr(make_instr(1'b1, 4'd15, 3'd2, 3'b001, COND_AL, 1'b0));
    repeat (2) send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b0));
    // AL block of one: the else bits lie beyond the length and are ignored.
    send_instr(make_instr(1'b1, COND_AL, 3'd1, 3'b111, COND_AL, 1'b0));
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b0));
    // Else under AL: no block opens, so the next IT is taken as a header.
    send_instr(make_instr(1'b1, COND_AL, 3'd3, 3'b010, COND_AL, 1'b0));
    // Zero length is taken as one.
    send_instr(make_instr(1'b1, 4'd1, 3'd0, 3'b111, COND_AL, 1'b0));
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b0));
    // Oversized length is clipped to four; an IT in a slot is a plain slot,
    // and a slot that is already conditional abandons the block.
    send_instr(make_instr(1'b1, 4'd2, 3'd7, 3'b111, COND_AL, 1'b0));
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b0));
    send_instr(make_instr(1'b1, 4'd9, 3'd2, 3'b011, COND_AL, 1'b0));
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, 4'd5, 1'b0));
    // IT as the last instruction of the stream.
    send_instr(make_instr(1'b1, 4'd3, 3'd3, 3'b000, COND_AL, 1'b1));
    // Stream ending in the middle of a block.
    send_instr(make_instr(1'b1, 4'd4, 3'd3, 3'b011, COND_AL, 1'b0));
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b0));
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b1));
    // Else under AL wins over an end of stream on the same IT.
    send_instr(make_instr(1'b1, COND_AL, 3'd2, 3'b001, COND_AL, 1'b1));
    // Stream ending exactly on the last slot is not an error.
    send_instr(make_instr(1'b1, 4'd6, 3'd2, 3'b000, COND_AL, 1'b0));
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b0));
    send_instr(make_instr(1'b0, 4'd0, 3'd0, 3'd0, COND_AL, 1'b1));

    // Random part: mostly well-formed blocks with random content, the rest
    // unconstrained instructions.
    while (beats_sent < RandomInstrs) begin
      if (!paused && beats_sent >= RandomInstrs / 2) begin
        // Let the pipeline run dry once with the sender held off.
        in_if.valid <= 1'b0;
        do @(negedge clk_i); while (board.outstanding() != 0);
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) sender_quiet = !sender_quiet;
      if ($urandom_range(0, 9) < 7) begin
        send_it_block();
      end else begin
        send_instr(random_instr());
      end
    end

    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (board.outstanding() != 0);
    // Keep the clock running so that any stray result beat would still be caught.
    repeat (10) @(negedge clk_i);

    $display("Run covered %0d instruction beats and %0d checked results; %0d IT blocks opened.",
             beats_sent, board.checked, board.blocks_opened);
    $display("Errors predicted: %0d else under AL, %0d conditional in block, %0d end in block.",
             board.flags_seen[ERR_ELSE_AL], board.flags_seen[ERR_COND_IN_BLK],
             board.flags_seen[ERR_END_IN_BLK]);
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tibce_pkg.sv
src/tibce_ifs.sv
src/tibce_core.sv
src/thumb_it_block_condition_expander_unit.sv
bench/tb_top.sv
